FILE: rtl/prtd_pkg.sv
// prtd_pkg: shared types, constants and the microcode table of the port
// rate trend detector. No dependencies.
package prtd_pkg;

  localparam int unsigned GAIN_BITS    = 16;
  localparam int unsigned IDLE_BITS    = 32;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned STEP_BITS    = 4;

  // whole-number parts of the reset thresholds, shifted into fixed point
  localparam int unsigned START_PERIOD_WHOLE = 100;
  localparam int unsigned START_ACCEL_WHOLE  = 10;
  localparam int unsigned STOP_PERIOD_WHOLE  = 5000;
  localparam int unsigned STOP_ACCEL_WHOLE   = 200;

  localparam logic [GAIN_BITS-1:0] PERIOD_GAIN_RST  = 16'd3277;
  localparam logic [GAIN_BITS-1:0] ACCEL_GAIN_RST   = 16'd13107;
  localparam logic [IDLE_BITS-1:0] IDLE_TIMEOUT_RST = 32'd1750000;

  localparam logic OPC_EVENT = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_GAIN  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL_GAIN   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_PERIOD = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_ACCEL  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_STOP_PERIOD  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_STOP_ACCEL   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_TIMEOUT = 3'd6;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_DIFF_P,
    ALU_UPD_P,
    ALU_ACC,
    ALU_DIFF_A,
    ALU_UPD_A,
    ALU_SEED
  } alu_e;

  typedef enum logic {
    GAIN_PERIOD,
    GAIN_ACCEL
  } gain_sel_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_QUERY,
    JMP_UNSEEDED,
    JMP_ALWAYS
  } jump_e;

  typedef struct packed {
    alu_e                 alu;
    logic                 mul_en;
    gain_sel_e            gain;
    jump_e                jmp;
    logic [STEP_BITS-1:0] target;
    logic                 fin;
  } ctrl_word_t;

  typedef struct packed {
    logic query;
    logic unseeded;
  } cond_t;

  typedef struct packed {
    logic play;
    logic stop;
    logic idle;
  } flags_t;

  localparam logic [STEP_BITS-1:0] STEP_DISPATCH = 4'd0;
  localparam logic [STEP_BITS-1:0] STEP_SEED_CHK = 4'd1;
  localparam logic [STEP_BITS-1:0] STEP_DIFF_P   = 4'd2;
  localparam logic [STEP_BITS-1:0] STEP_MUL_P    = 4'd3;
  localparam logic [STEP_BITS-1:0] STEP_UPD_P    = 4'd4;
  localparam logic [STEP_BITS-1:0] STEP_ACC      = 4'd5;
  localparam logic [STEP_BITS-1:0] STEP_DIFF_A   = 4'd6;
  localparam logic [STEP_BITS-1:0] STEP_MUL_A    = 4'd7;
  localparam logic [STEP_BITS-1:0] STEP_UPD_A    = 4'd8;
  localparam logic [STEP_BITS-1:0] STEP_SEED     = 4'd9;
  localparam logic [STEP_BITS-1:0] STEP_FIN      = 4'd10;

  function automatic ctrl_word_t mk_cw(input alu_e alu, input logic mul_en,
                                       input gain_sel_e gain, input jump_e jmp,
                                       input logic [STEP_BITS-1:0] target,
                                       input logic fin);
    ctrl_word_t w;
    w.alu    = alu;
    w.mul_en = mul_en;
    w.gain   = gain;
    w.jmp    = jmp;
    w.target = target;
    w.fin    = fin;
    return w;
  endfunction

  // One control word per step; fin marks the step that presents the result.
  function automatic ctrl_word_t ucode_rom(input logic [STEP_BITS-1:0] addr);
    ctrl_word_t w;
    unique case (addr)
      STEP_DISPATCH: w = mk_cw(ALU_NOP, 1'b0, GAIN_PERIOD, JMP_QUERY, STEP_FIN, 1'b0);
      STEP_SEED_CHK: w = mk_cw(ALU_NOP, 1'b0, GAIN_PERIOD, JMP_UNSEEDED, STEP_SEED, 1'b0);
      STEP_DIFF_P:   w = mk_cw(ALU_DIFF_P, 1'b0, GAIN_PERIOD, JMP_NONE, STEP_DISPATCH, 1'b0);
      STEP_MUL_P:    w = mk_cw(ALU_NOP, 1'b1, GAIN_PERIOD, JMP_NONE, STEP_DISPATCH, 1'b0);
      STEP_UPD_P:    w = mk_cw(ALU_UPD_P, 1'b0, GAIN_PERIOD, JMP_NONE, STEP_DISPATCH, 1'b0);
      STEP_ACC:      w = mk_cw(ALU_ACC, 1'b0, GAIN_PERIOD, JMP_NONE, STEP_DISPATCH, 1'b0);
      STEP_DIFF_A:   w = mk_cw(ALU_DIFF_A, 1'b0, GAIN_ACCEL, JMP_NONE, STEP_DISPATCH, 1'b0);
      STEP_MUL_A:    w = mk_cw(ALU_NOP, 1'b1, GAIN_ACCEL, JMP_NONE, STEP_DISPATCH, 1'b0);
      STEP_UPD_A:    w = mk_cw(ALU_UPD_A, 1'b0, GAIN_ACCEL, JMP_ALWAYS, STEP_FIN, 1'b0);
      STEP_SEED:     w = mk_cw(ALU_SEED, 1'b0, GAIN_PERIOD, JMP_NONE, STEP_DISPATCH, 1'b0);
      default:       w = mk_cw(ALU_NOP, 1'b0, GAIN_PERIOD, JMP_NONE, STEP_DISPATCH, 1'b1);
    endcase
    return w;
  endfunction

  function automatic ctrl_word_t nop_cw();
    return mk_cw(ALU_NOP, 1'b0, GAIN_PERIOD, JMP_NONE, STEP_DISPATCH, 1'b0);
  endfunction

endpackage

FILE: rtl/prtd_cfg_regs.sv
// prtd_cfg_regs: configuration register file with reset defaults.
// Depends on prtd_pkg.
module prtd_cfg_regs #(
  parameter int unsigned FRAC_BITS     = 16,
  parameter int unsigned INTERVAL_BITS = 24,
  parameter int unsigned CFG_W         = 41
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [prtd_pkg::CFG_IDX_BITS-1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]                           cfg_data_i,
  output logic [prtd_pkg::GAIN_BITS-1:0]             period_gain_o,
  output logic [prtd_pkg::GAIN_BITS-1:0]             accel_gain_o,
  output logic [INTERVAL_BITS+FRAC_BITS-1:0]         start_period_o,
  output logic signed [INTERVAL_BITS+FRAC_BITS:0]    start_accel_o,
  output logic [INTERVAL_BITS+FRAC_BITS-1:0]         stop_period_o,
  output logic signed [INTERVAL_BITS+FRAC_BITS:0]    stop_accel_o,
  output logic [prtd_pkg::IDLE_BITS-1:0]             idle_timeout_o
);

  localparam int unsigned PW = INTERVAL_BITS + FRAC_BITS;
  localparam int unsigned AW = PW + 1;
  localparam int unsigned GW = prtd_pkg::GAIN_BITS;
  localparam int unsigned IW = prtd_pkg::IDLE_BITS;

  logic [GW-1:0]        period_gain_q, accel_gain_q;
  logic [PW-1:0]        start_period_q, stop_period_q;
  logic signed [AW-1:0] start_accel_q, stop_accel_q;
  logic [IW-1:0]        idle_timeout_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_gain_q  <= prtd_pkg::PERIOD_GAIN_RST;
      accel_gain_q   <= prtd_pkg::ACCEL_GAIN_RST;
      start_period_q <= PW'(prtd_pkg::START_PERIOD_WHOLE) << FRAC_BITS;
      start_accel_q  <= AW'(prtd_pkg::START_ACCEL_WHOLE) << FRAC_BITS;
      stop_period_q  <= PW'(prtd_pkg::STOP_PERIOD_WHOLE) << FRAC_BITS;
      stop_accel_q   <= AW'(prtd_pkg::STOP_ACCEL_WHOLE) << FRAC_BITS;
      idle_timeout_q <= prtd_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      // an index beyond the list writes nothing
      unique case (cfg_index_i)
        prtd_pkg::REG_PERIOD_GAIN:  period_gain_q  <= cfg_data_i[GW-1:0];
        prtd_pkg::REG_ACCEL_GAIN:   accel_gain_q   <= cfg_data_i[GW-1:0];
        prtd_pkg::REG_START_PERIOD: start_period_q <= cfg_data_i[PW-1:0];
        prtd_pkg::REG_START_ACCEL:  start_accel_q  <= $signed(cfg_data_i[AW-1:0]);
        prtd_pkg::REG_STOP_PERIOD:  stop_period_q  <= cfg_data_i[PW-1:0];
        prtd_pkg::REG_STOP_ACCEL:   stop_accel_q   <= $signed(cfg_data_i[AW-1:0]);
        prtd_pkg::REG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data_i[IW-1:0];
        default: ;
      endcase
    end
  end

  assign period_gain_o  = period_gain_q;
  assign accel_gain_o   = accel_gain_q;
  assign start_period_o = start_period_q;
  assign start_accel_o  = start_accel_q;
  assign stop_period_o  = stop_period_q;
  assign stop_accel_o   = stop_accel_q;
  assign idle_timeout_o = idle_timeout_q;

endmodule

FILE: rtl/prtd_sequencer.sv
// prtd_sequencer: step counter over the microcode table with conditional
// jumps. Depends on prtd_pkg.
module prtd_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 hold_i,
  input  prtd_pkg::cond_t      cond_i,
  output prtd_pkg::ctrl_word_t ctrl_o,
  output logic                 busy_o
);

  logic                           busy_q, busy_d;
  logic [prtd_pkg::STEP_BITS-1:0] pc_q, pc_d;
  prtd_pkg::ctrl_word_t           word;
  logic                           take;

  assign word = prtd_pkg::ucode_rom(pc_q);

  always_comb begin
    unique case (word.jmp)
      prtd_pkg::JMP_NONE:     take = 1'b0;
      prtd_pkg::JMP_QUERY:    take = cond_i.query;
      prtd_pkg::JMP_UNSEEDED: take = cond_i.unseeded;
      prtd_pkg::JMP_ALWAYS:   take = 1'b1;
      default:                take = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = prtd_pkg::STEP_DISPATCH;
      end
    end else if (word.fin) begin
      // hold the final step until the output register frees up
      if (!hold_i) begin
        busy_d = 1'b0;
      end
    end else if (take) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= prtd_pkg::STEP_DISPATCH;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign ctrl_o = busy_q ? word : prtd_pkg::nop_cw();
  assign busy_o = busy_q;

endmodule

FILE: rtl/prtd_datapath.sv
// prtd_datapath: smoothing state, shared difference unit, shared gain
// multiplier and the result compares. Depends on prtd_pkg.
module prtd_datapath #(
  parameter int unsigned FRAC_BITS     = 16,
  parameter int unsigned INTERVAL_BITS = 24,
  parameter int unsigned TIME_BITS     = 48
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  prtd_pkg::ctrl_word_t                    ctrl_i,
  input  logic [INTERVAL_BITS-1:0]                interval_i,
  input  logic [TIME_BITS-1:0]                    timestamp_i,
  input  logic [prtd_pkg::GAIN_BITS-1:0]          period_gain_i,
  input  logic [prtd_pkg::GAIN_BITS-1:0]          accel_gain_i,
  input  logic [INTERVAL_BITS+FRAC_BITS-1:0]      start_period_i,
  input  logic signed [INTERVAL_BITS+FRAC_BITS:0] start_accel_i,
  input  logic [INTERVAL_BITS+FRAC_BITS-1:0]      stop_period_i,
  input  logic signed [INTERVAL_BITS+FRAC_BITS:0] stop_accel_i,
  input  logic [prtd_pkg::IDLE_BITS-1:0]          idle_timeout_i,
  output logic                                    seeded_o,
  output prtd_pkg::flags_t                        flags_o,
  output logic [INTERVAL_BITS+FRAC_BITS-1:0]      smoothed_period_o,
  output logic signed [INTERVAL_BITS+FRAC_BITS:0] smoothed_accel_o
);

  localparam int unsigned PW  = INTERVAL_BITS + FRAC_BITS;
  localparam int unsigned AW  = PW + 1;
  localparam int unsigned DW  = AW + 1;
  localparam int unsigned GW  = prtd_pkg::GAIN_BITS;
  localparam int unsigned PRW = DW + GW;

  logic [PW-1:0]        avg_period_q, avg_period_d;
  logic [PW-1:0]        prev_period_q, prev_period_d;
  logic signed [AW-1:0] avg_accel_q, avg_accel_d;
  logic [TIME_BITS-1:0] last_time_q, last_time_d;
  logic                 seeded_q, seeded_d;

  logic signed [AW-1:0] acc_q;
  logic [DW-1:0]        mag_q, q_q;
  logic                 neg_q;

  logic [PW-1:0]        x;
  logic signed [DW-1:0] opa, opb, diff_ab, diff_ba, upd_base, upd_sum;
  logic                 opa_lt;
  logic [GW-1:0]        gain;
  logic [PRW-1:0]       prod;
  logic signed [AW-1:0] acc_d;
  logic [TIME_BITS-1:0] elapsed;

  assign x = {interval_i, {FRAC_BITS{1'b0}}};

  // difference unit: sign and magnitude of opa - opb
  always_comb begin
    if (ctrl_i.alu == prtd_pkg::ALU_DIFF_A) begin
      opa = DW'(acc_q);
      opb = DW'(avg_accel_q);
    end else begin
      opa = $signed({2'b00, x});
      opb = $signed({2'b00, avg_period_q});
    end
  end

  assign diff_ab = opa - opb;
  assign diff_ba = opb - opa;
  assign opa_lt  = opa < opb;

  // gain multiply, rounded to nearest on the magnitude
  assign gain = (ctrl_i.gain == prtd_pkg::GAIN_ACCEL) ? accel_gain_i : period_gain_i;
  assign prod = PRW'(mag_q) * PRW'(gain) + (PRW'(1) << (GW - 1));

  // apply the signed correction to the selected average
  assign upd_base = (ctrl_i.alu == prtd_pkg::ALU_UPD_A) ? DW'(avg_accel_q)
                                                        : $signed({2'b00, avg_period_q});
  assign upd_sum  = neg_q ? upd_base - $signed(q_q) : upd_base + $signed(q_q);

  assign acc_d = $signed({1'b0, prev_period_q}) - $signed({1'b0, avg_period_q});

  always_comb begin
    avg_period_d  = avg_period_q;
    prev_period_d = prev_period_q;
    avg_accel_d   = avg_accel_q;
    last_time_d   = last_time_q;
    seeded_d      = seeded_q;
    unique case (ctrl_i.alu)
      prtd_pkg::ALU_NOP,
      prtd_pkg::ALU_DIFF_P,
      prtd_pkg::ALU_DIFF_A: ;
      prtd_pkg::ALU_SEED: begin
        avg_period_d  = x;
        prev_period_d = x;
        avg_accel_d   = '0;
        seeded_d      = 1'b1;
      end
      prtd_pkg::ALU_UPD_P: begin
        avg_period_d = upd_sum[PW-1:0];
      end
      prtd_pkg::ALU_ACC: begin
        prev_period_d = avg_period_q;
      end
      prtd_pkg::ALU_UPD_A: begin
        avg_accel_d = $signed(upd_sum[AW-1:0]);
        last_time_d = timestamp_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_period_q  <= '0;
      prev_period_q <= '0;
      avg_accel_q   <= '0;
      last_time_q   <= '0;
      seeded_q      <= 1'b0;
    end else begin
      avg_period_q  <= avg_period_d;
      prev_period_q <= prev_period_d;
      avg_accel_q   <= avg_accel_d;
      last_time_q   <= last_time_d;
      seeded_q      <= seeded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.alu == prtd_pkg::ALU_DIFF_P || ctrl_i.alu == prtd_pkg::ALU_DIFF_A) begin
      mag_q <= opa_lt ? $unsigned(diff_ba) : $unsigned(diff_ab);
      neg_q <= opa_lt;
    end
    if (ctrl_i.mul_en) begin
      q_q <= prod[PRW-1:GW];
    end
    if (ctrl_i.alu == prtd_pkg::ALU_ACC) begin
      acc_q <= acc_d;
    end
  end

  assign elapsed = timestamp_i - last_time_q;

  assign flags_o.play = (avg_period_q > start_period_i) && (avg_accel_q > start_accel_i);
  assign flags_o.stop = (avg_period_q < stop_period_i) && (avg_accel_q < stop_accel_i);
  assign flags_o.idle = elapsed > TIME_BITS'(idle_timeout_i);

  assign seeded_o          = seeded_q;
  assign smoothed_period_o = avg_period_q;
  assign smoothed_accel_o  = avg_accel_q;

endmodule

FILE: rtl/port_rate_trend_detector.sv
// port_rate_trend_detector: top level; input capture, output register and
// the wiring of sequencer, datapath and config registers. Depends on prtd_pkg.
//
//   channel   handshake                 payload
//   --------  ------------------------  -----------------------------------------
//   in        in_valid_i / in_stall_o   opcode_i, interval_i, timestamp_i
//   out       out_valid_o / out_stall_i play/stop/idle_detected_o, smoothed_*_o
//   cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One word at a time runs through the microcode sequencer: a query takes 2
// steps, a seeding event 4, a tracking event 10 (two difference, two multiply
// and three update steps through the shared unit); in_stall_o drops the cycle
// after the last step. Reset clears the smoothing state and loads the default
// thresholds. A stalled output holds the last step; a new word is taken while
// the finished result still waits in the output register.
module port_rate_trend_detector #(
  parameter int unsigned FRAC_BITS     = 16,
  parameter int unsigned INTERVAL_BITS = 24,
  parameter int unsigned TIME_BITS     = 48,
  localparam int unsigned CfgW = (INTERVAL_BITS + FRAC_BITS + 1 > prtd_pkg::IDLE_BITS)
                                 ? INTERVAL_BITS + FRAC_BITS + 1 : prtd_pkg::IDLE_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    opcode_i,
  input  logic [INTERVAL_BITS-1:0]                interval_i,
  input  logic [TIME_BITS-1:0]                    timestamp_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    play_detected_o,
  output logic                                    stop_detected_o,
  output logic                                    idle_detected_o,
  output logic [INTERVAL_BITS+FRAC_BITS-1:0]      smoothed_period_o,
  output logic signed [INTERVAL_BITS+FRAC_BITS:0] smoothed_accel_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [prtd_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [CfgW-1:0]                         cfg_data_i
);

  localparam int unsigned PW = INTERVAL_BITS + FRAC_BITS;
  localparam int unsigned AW = PW + 1;
  localparam int unsigned GW = prtd_pkg::GAIN_BITS;
  localparam int unsigned IW = prtd_pkg::IDLE_BITS;

  logic [GW-1:0]        period_gain, accel_gain;
  logic [PW-1:0]        start_period, stop_period;
  logic signed [AW-1:0] start_accel, stop_accel;
  logic [IW-1:0]        idle_timeout;

  logic                 busy, accept, hold, load, seeded;
  prtd_pkg::ctrl_word_t ctrl;
  prtd_pkg::cond_t      cond;
  prtd_pkg::flags_t     flags;
  logic [PW-1:0]        period_val;
  logic signed [AW-1:0] accel_val;

  logic                     op_q;
  logic [INTERVAL_BITS-1:0] interval_q;
  logic [TIME_BITS-1:0]     ts_q;

  logic                 out_valid_q, out_valid_d;
  prtd_pkg::flags_t     flags_q;
  logic [PW-1:0]        period_q;
  logic signed [AW-1:0] accel_q;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;
  assign hold       = out_valid_q && out_stall_i;
  assign load       = ctrl.fin && !hold;

  assign cond.query    = (op_q == prtd_pkg::OPC_QUERY);
  assign cond.unseeded = !seeded;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= opcode_i;
      interval_q <= interval_i;
      ts_q       <= timestamp_i;
    end
    if (load) begin
      flags_q  <= flags;
      period_q <= period_val;
      accel_q  <= accel_val;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  prtd_cfg_regs #(
    .FRAC_BITS     (FRAC_BITS),
    .INTERVAL_BITS (INTERVAL_BITS),
    .CFG_W         (CfgW)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .period_gain_o  (period_gain),
    .accel_gain_o   (accel_gain),
    .start_period_o (start_period),
    .start_accel_o  (start_accel),
    .stop_period_o  (stop_period),
    .stop_accel_o   (stop_accel),
    .idle_timeout_o (idle_timeout)
  );

  prtd_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .hold_i  (hold),
    .cond_i  (cond),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  prtd_datapath #(
    .FRAC_BITS     (FRAC_BITS),
    .INTERVAL_BITS (INTERVAL_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .interval_i        (interval_q),
    .timestamp_i       (ts_q),
    .period_gain_i     (period_gain),
    .accel_gain_i      (accel_gain),
    .start_period_i    (start_period),
    .start_accel_i     (start_accel),
    .stop_period_i     (stop_period),
    .stop_accel_i      (stop_accel),
    .idle_timeout_i    (idle_timeout),
    .seeded_o          (seeded),
    .flags_o           (flags),
    .smoothed_period_o (period_val),
    .smoothed_accel_o  (accel_val)
  );

  assign out_valid_o       = out_valid_q;
  assign play_detected_o   = flags_q.play;
  assign stop_detected_o   = flags_q.stop;
  assign idle_detected_o   = flags_q.idle;
  assign smoothed_period_o = period_q;
  assign smoothed_accel_o  = accel_q;

endmodule
